### rtl/tga_rle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
package tga_rle_pkg;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRleMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFourByte  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPixCount  = 2'd2;

  // Packet header decoding
  localparam logic [7:0] RepeatBias  = 8'd127;
  localparam logic [7:0] OpaqueAlpha = 8'd255;

  // Queue between front and back
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic        rle_mode;
    logic        four_byte_pixels;
    logic [31:0] pixel_count;
  } cfg_t;

  // One assembled pixel handed from front to back
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_len;      // unclamped run length, 1..128
    logic        last;         // this pixel completes the image
    logic [31:0] pixels_done;  // pixels emitted before this one
  } pixel_rec_t;

endpackage

### rtl/tga_rle_front.sv
// Front end: parses packet headers, gathers pixel bytes, tracks image position.
module tga_rle_front (
  input  logic                   clk,
  input  logic                   rst,
  input  tga_rle_pkg::cfg_t      cfg,
  input  logic                   push,
  input  logic [7:0]             data_byte,
  input  logic                   rec_full,
  output logic                   rec_push,
  output tga_rle_pkg::pixel_rec_t rec
);

  logic        expect_header, expect_header_next;
  logic        in_repeat, in_repeat_next;
  logic [6:0]  lit_left, lit_left_next;
  logic [7:0]  rep_len, rep_len_next;
  logic [1:0]  byte_pos, byte_pos_next;
  logic [23:0] gathered, gathered_next;
  logic [31:0] pixels_done, pixels_done_next;

  logic        accept;
  logic        is_header;
  logic        complete;
  logic [1:0]  last_pos;
  logic [7:0]  run_len;
  logic [31:0] total;
  logic [32:0] done_sum;
  logic        is_last;

  assign accept    = push && !rec_full;
  assign last_pos  = cfg.four_byte_pixels ? 2'd3 : 2'd2;
  assign is_header = cfg.rle_mode && expect_header;
  assign complete  = !is_header && (byte_pos >= last_pos);
  assign run_len   = (cfg.rle_mode && in_repeat) ? ((rep_len == 8'd0) ? 8'd1 : rep_len) : 8'd1;
  assign total     = (cfg.pixel_count == 32'd0) ? 32'd1 : cfg.pixel_count;
  assign done_sum  = {1'b0, pixels_done} + {25'd0, run_len};
  assign is_last   = done_sum >= {1'b0, total};

  assign rec_push        = accept && complete;
  assign rec.red         = (byte_pos == 2'd2) ? data_byte : gathered[23:16];
  assign rec.green       = gathered[15:8];
  assign rec.blue        = gathered[7:0];
  assign rec.alpha       = cfg.four_byte_pixels ? data_byte : tga_rle_pkg::OpaqueAlpha;
  assign rec.run_len     = run_len;
  assign rec.last        = is_last;
  assign rec.pixels_done = pixels_done;

  always_comb begin
    expect_header_next = expect_header;
    in_repeat_next     = in_repeat;
    lit_left_next      = lit_left;
    rep_len_next       = rep_len;
    byte_pos_next      = byte_pos;
    gathered_next      = gathered;
    pixels_done_next   = pixels_done;
    if (accept) begin
      if (is_header) begin
        if (!data_byte[7]) begin
          in_repeat_next = 1'b0;
          lit_left_next  = data_byte[6:0];
        end else begin
          in_repeat_next = 1'b1;
          rep_len_next   = data_byte - tga_rle_pkg::RepeatBias;
        end
        expect_header_next = 1'b0;
        byte_pos_next      = 2'd0;
      end else if (!complete) begin
        case (byte_pos)
          2'd0:    gathered_next[7:0]   = data_byte;
          2'd1:    gathered_next[15:8]  = data_byte;
          2'd2:    gathered_next[23:16] = data_byte;
          default: gathered_next        = gathered;
        endcase
        byte_pos_next = byte_pos + 2'd1;
      end else begin
        byte_pos_next = 2'd0;
        if (is_last) begin
          // image done: restart for the next one
          expect_header_next = 1'b1;
          in_repeat_next     = 1'b0;
          lit_left_next      = 7'd0;
          rep_len_next       = 8'd0;
          pixels_done_next   = 32'd0;
        end else begin
          pixels_done_next = done_sum[31:0];
          if (cfg.rle_mode) begin
            if (in_repeat || (lit_left == 7'd0)) begin
              expect_header_next = 1'b1;
            end else begin
              lit_left_next = lit_left - 7'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      in_repeat     <= 1'b0;
      lit_left      <= 7'd0;
      rep_len       <= 8'd0;
      byte_pos      <= 2'd0;
      pixels_done   <= 32'd0;
    end else begin
      expect_header <= expect_header_next;
      in_repeat     <= in_repeat_next;
      lit_left      <= lit_left_next;
      rep_len       <= rep_len_next;
      byte_pos      <= byte_pos_next;
      pixels_done   <= pixels_done_next;
    end
  end

  always_ff @(posedge clk) begin
    gathered <= gathered_next;
  end

  a_last_reopens_header: assert property (@(posedge clk) disable iff (rst)
    (rec_push && rec.last) |=> (expect_header && pixels_done == 32'd0))
    else $error("image end did not restart the decoder");

endmodule

### rtl/tga_rle_queue.sv
// Short pixel-record queue between front and back.
module tga_rle_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  tga_rle_pkg::pixel_rec_t wr_data,
  output logic                   full,
  input  logic                   rd_en,
  output logic                   rd_valid,
  output tga_rle_pkg::pixel_rec_t rd_data
);

  tga_rle_pkg::pixel_rec_t slots [tga_rle_pkg::QueueDepth];
  logic [tga_rle_pkg::QueuePtrW-1:0] wr_ptr, rd_ptr;
  logic [tga_rle_pkg::QueueCntW-1:0] fill;
  logic do_wr, do_rd;

  assign full     = (fill == tga_rle_pkg::QueueCntW'(tga_rle_pkg::QueueDepth));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + tga_rle_pkg::QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + tga_rle_pkg::QueuePtrW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + tga_rle_pkg::QueueCntW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - tga_rle_pkg::QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= tga_rle_pkg::QueueCntW'(tga_rle_pkg::QueueDepth))
    else $error("queue fill count out of range");

endmodule

### rtl/tga_rle_back.sv
// Back end: clamps run length at image end and holds the result register.
module tga_rle_back (
  input  logic                    clk,
  input  logic                    rst,
  input  tga_rle_pkg::cfg_t       cfg,
  input  logic                    rec_valid,
  input  tga_rle_pkg::pixel_rec_t rec,
  output logic                    rec_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic [7:0]              red,
  output logic [7:0]              green,
  output logic [7:0]              blue,
  output logic [7:0]              alpha,
  output logic [7:0]              repeat_count,
  output logic                    last_pixel,
  output logic                    overrun
);

  logic        out_valid;
  logic [31:0] total;
  logic [31:0] remaining;
  logic [7:0]  count_next;
  logic        overrun_next;

  assign total     = (cfg.pixel_count == 32'd0) ? 32'd1 : cfg.pixel_count;
  assign remaining = (rec.pixels_done < total) ? (total - rec.pixels_done) : 32'd1;
  // On the last pixel what remains never exceeds the run, so it fits in 8 bits
  assign count_next   = rec.last ? remaining[7:0] : rec.run_len;
  assign overrun_next = rec.last && ({24'd0, rec.run_len} > remaining);

  assign rec_pop = rec_valid && (!out_valid || pop);
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      red          <= rec.red;
      green        <= rec.green;
      blue         <= rec.blue;
      alpha        <= rec.alpha;
      repeat_count <= count_next;
      last_pixel   <= rec.last;
      overrun      <= overrun_next;
    end
  end

  a_overrun_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overrun) |-> last_pixel)
    else $error("overrun flagged on a pixel that is not last");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (repeat_count != 8'd0))
    else $error("zero repeat count on output");

endmodule

### rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: config registers and the front/queue/back chain.
// A pixel's result passes through the pixel queue and then the output register before it shows on the output.
// Throughput: one data byte per cycle; header and leading pixel bytes produce no beat.
// The input stalls only when the four-entry pixel queue fills behind a stalled output.
// Reset (rst, synchronous) restores rle_mode=1, four_byte_pixels=1, pixel_count=1,
// empties both queue and output register, and arms the decoder for a packet header.
module tga_rle_pixel_decoder (
  input  logic                              clk,
  input  logic                              rst,
  // byte input, queue style
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        data_byte,
  // pixel output, queue style
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic [7:0]                        alpha,
  output logic [7:0]                        repeat_count,
  output logic                              last_pixel,
  output logic                              overrun,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tga_rle_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data
);

  tga_rle_pkg::cfg_t       cfg;
  tga_rle_pkg::pixel_rec_t front_rec;
  tga_rle_pkg::pixel_rec_t head_rec;
  logic                    front_push;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;

  // Config writes are always taken; the block leaves it to software to write only while the decoder is idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rle_mode         <= 1'b1;
      cfg.four_byte_pixels <= 1'b1;
      cfg.pixel_count      <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tga_rle_pkg::CfgRleMode:  cfg.rle_mode         <= cfg_data[0];
        tga_rle_pkg::CfgFourByte: cfg.four_byte_pixels <= cfg_data[0];
        tga_rle_pkg::CfgPixCount: cfg.pixel_count      <= cfg_data;
        default:                  cfg                  <= cfg;  // drop unknown index
      endcase
    end
  end

  // Hold off input whenever the pixel queue is full.
  assign full = q_full;

  tga_rle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .push      (push),
    .data_byte (data_byte),
    .rec_full  (q_full),
    .rec_push  (front_push),
    .rec       (front_rec)
  );

  // Queue decouples header parsing from run clamping and the output register.
  tga_rle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_push),
    .wr_data  (front_rec),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (head_rec)
  );

  // Advance the queue head into the output register whenever it is free or being popped.
  tga_rle_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rec_valid    (q_valid),
    .rec          (head_rec),
    .rec_pop      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .repeat_count (repeat_count),
    .last_pixel   (last_pixel),
    .overrun      (overrun)
  );

endmodule
